[rtl/core/uas_pkg.sv]
// Shared types and character constants for the URL authority splitter.
`default_nettype none

package uas_pkg;

    typedef enum logic [1:0] {
        PH_SCHEME,
        PH_HOST,
        PH_PORT,
        PH_URI
    } phase_t;

    typedef enum logic [2:0] {
        ERR_OK        = 3'd0,
        ERR_NO_SEP    = 3'd1,
        ERR_HOST_CHAR = 3'd2,
        ERR_SCHEME    = 3'd3,
        ERR_TOO_LONG  = 3'd4
    } err_t;

    localparam int unsigned LEN_W  = 13;
    localparam int unsigned PORT_W = 16;

    localparam logic [7:0] CH_SLASH    = 8'h2F;
    localparam logic [7:0] CH_QUESTION = 8'h3F;
    localparam logic [7:0] CH_HASH     = 8'h23;
    localparam logic [7:0] CH_COLON    = 8'h3A;
    localparam logic [7:0] CH_DOT      = 8'h2E;
    localparam logic [7:0] CH_DASH     = 8'h2D;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;
    localparam logic [7:0] CH_LOWER_A  = 8'h61;
    localparam logic [7:0] CH_LOWER_Z  = 8'h7A;
    localparam logic [7:0] CH_LOWER_S  = 8'h73;

    // "http", one character per position
    localparam int unsigned HTTP_LEN  = 4;
    localparam int unsigned HTTPS_LEN = 5;
    localparam logic [7:0] HTTP_WORD [HTTP_LEN] = '{8'h68, 8'h74, 8'h74, 8'h70};

    localparam logic [PORT_W-1:0] PORT_HTTP  = 16'd80;
    localparam logic [PORT_W-1:0] PORT_HTTPS = 16'd443;

    // Parse state after the byte just taken, as seen by the result logic
    typedef struct packed {
        logic              too_long;
        logic              sep_seen;
        logic [LEN_W-1:0]  url_len;
        logic [LEN_W-1:0]  scheme_len;
        logic              scheme_len_http;
        logic              scheme_len_https;
        logic              http_prefix_ok;
        logic              https_tail_ok;
        logic [LEN_W-1:0]  host_len;
        logic [LEN_W-1:0]  domain_len;
        logic [PORT_W-1:0] port_acc;
        logic              colon_seen;
        logic              host_bad;
    } uas_summary_t;

endpackage

`default_nettype wire

[rtl/core/uas_if.sv]
// Channel interfaces: URL bytes in, authority results out.
`default_nettype none

interface uas_byte_if;
    import uas_pkg::*;

    logic       valid;
    logic       ready;
    logic [7:0] url_byte;
    logic       last_byte;

    modport source (output valid, output url_byte, output last_byte, input ready);
    modport sink (input valid, input url_byte, input last_byte, output ready);
    modport monitor (input valid, input url_byte, input last_byte, input ready);
endinterface

interface uas_result_if;
    import uas_pkg::*;

    logic              valid;
    logic              ready;
    logic [LEN_W-1:0]  scheme_length;
    logic [LEN_W-1:0]  host_length;
    logic [LEN_W-1:0]  domain_length;
    logic [PORT_W-1:0] port_number;
    logic              port_explicit;
    logic [LEN_W-1:0]  uri_start;
    logic [LEN_W-1:0]  url_length;
    logic [2:0]        error_code;

    modport source (
        output valid, output scheme_length, output host_length, output domain_length,
        output port_number, output port_explicit, output uri_start, output url_length,
        output error_code, input ready
    );
    modport sink (
        input valid, input scheme_length, input host_length, input domain_length,
        input port_number, input port_explicit, input uri_start, input url_length,
        input error_code, output ready
    );
    modport monitor (
        input valid, input scheme_length, input host_length, input domain_length,
        input port_number, input port_explicit, input uri_start, input url_length,
        input error_code, input ready
    );
endinterface

`default_nettype wire

[rtl/core/uas_parser.sv]
// Per-byte parse state: scheme, host, port digits and lengths.
`default_nettype none

module uas_parser
    import uas_pkg::*;
#(
    parameter int unsigned MAX_URL_LENGTH = 4096
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         take,
    input  wire logic [7:0]   url_byte,
    input  wire logic         last_byte,
    output uas_summary_t      summary
);

    localparam int unsigned PW = $clog2(MAX_URL_LENGTH + 2);
    localparam logic [PW-1:0] POS_LIMIT = PW'(MAX_URL_LENGTH);
    localparam logic [PW-1:0] POS_OVER  = PW'(MAX_URL_LENGTH + 1);

    logic [PW-1:0]     pos_reg, pos_next;
    phase_t            phase_reg, phase_next;
    logic [7:0]        prev0_reg, prev0_next;
    logic [7:0]        prev1_reg, prev1_next;
    logic              http_ok_reg, http_ok_next;
    logic              tail_ok_reg, tail_ok_next;
    logic [PW-1:0]     scheme_len_reg, scheme_len_next;
    logic [LEN_W-1:0]  domain_len_reg, domain_len_next;
    logic [LEN_W-1:0]  host_len_reg, host_len_next;
    logic [PORT_W-1:0] port_acc_reg, port_acc_next;
    logic              digits_ended_reg, digits_ended_next;
    logic              colon_reg, colon_next;
    logic              host_bad_reg, host_bad_next;

    logic              in_range;
    logic              is_end;
    logic              is_colon;
    logic              is_digit;
    logic              host_ok;
    logic              sep_found;
    logic [PW+LEN_W-1:0] pos_wide;
    logic [PW+LEN_W-1:0] scheme_wide;

    assign in_range = pos_reg < POS_LIMIT;
    assign is_end   = (url_byte == CH_SLASH) || (url_byte == CH_QUESTION)
                   || (url_byte == CH_HASH);
    assign is_colon = url_byte == CH_COLON;
    assign is_digit = (url_byte >= CH_ZERO) && (url_byte <= CH_NINE);
    assign host_ok  = ((url_byte >= CH_LOWER_A) && (url_byte <= CH_LOWER_Z)) || is_digit
                   || (url_byte == CH_DOT) || (url_byte == CH_DASH);
    assign sep_found = in_range && (phase_reg == PH_SCHEME) && (url_byte == CH_SLASH)
                    && (prev0_reg == CH_SLASH) && (prev1_reg == CH_COLON);

    // Phase transitions
    always_comb
    begin
        phase_next = phase_reg;
        if (in_range)
        begin
            unique case (phase_reg)
                PH_SCHEME:
                begin
                    if (sep_found)
                        phase_next = PH_HOST;
                end
                PH_HOST:
                begin
                    if (is_end)
                        phase_next = PH_URI;
                    else if (is_colon)
                        phase_next = PH_PORT;
                end
                PH_PORT:
                begin
                    if (is_end)
                        phase_next = PH_URI;
                end
                PH_URI:
                begin
                    phase_next = PH_URI;
                end
            endcase
        end
    end

    // Datapath updates for the byte on the input
    always_comb
    begin
        pos_next          = in_range ? pos_reg + PW'(1) : POS_OVER;
        prev0_next        = prev0_reg;
        prev1_next        = prev1_reg;
        http_ok_next      = http_ok_reg;
        tail_ok_next      = tail_ok_reg;
        scheme_len_next   = scheme_len_reg;
        domain_len_next   = domain_len_reg;
        host_len_next     = host_len_reg;
        port_acc_next     = port_acc_reg;
        digits_ended_next = digits_ended_reg;
        colon_next        = colon_reg;
        host_bad_next     = host_bad_reg;
        if (in_range)
        begin
            unique case (phase_reg)
                PH_SCHEME:
                begin
                    if ((pos_reg < PW'(HTTP_LEN)) && (url_byte != HTTP_WORD[pos_reg[1:0]]))
                        http_ok_next = 1'b0;
                    if (pos_reg == PW'(HTTP_LEN))
                        tail_ok_next = url_byte == CH_LOWER_S;
                    if (sep_found)
                        scheme_len_next = pos_reg - PW'(2);
                    prev1_next = prev0_reg;
                    prev0_next = url_byte;
                end
                PH_HOST:
                begin
                    if (!is_end)
                    begin
                        domain_len_next = domain_len_reg + LEN_W'(1);
                        if (is_colon)
                            colon_next = 1'b1;
                        else
                        begin
                            host_len_next = host_len_reg + LEN_W'(1);
                            if (!host_ok)
                                host_bad_next = 1'b1;
                        end
                    end
                end
                PH_PORT:
                begin
                    if (!is_end)
                    begin
                        domain_len_next = domain_len_reg + LEN_W'(1);
                        if (!digits_ended_reg)
                        begin
                            if (is_digit)
                                // times ten as 8x + 2x, wrapping at 16 bits
                                port_acc_next = (port_acc_reg << 3) + (port_acc_reg << 1)
                                              + PORT_W'(url_byte - CH_ZERO);
                            else
                                digits_ended_next = 1'b1;
                        end
                    end
                end
                PH_URI:
                begin
                    port_acc_next = port_acc_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg          <= '0;
            phase_reg        <= PH_SCHEME;
            prev0_reg        <= '0;
            prev1_reg        <= '0;
            http_ok_reg      <= 1'b1;
            tail_ok_reg      <= 1'b0;
            scheme_len_reg   <= '0;
            domain_len_reg   <= '0;
            host_len_reg     <= '0;
            port_acc_reg     <= '0;
            digits_ended_reg <= 1'b0;
            colon_reg        <= 1'b0;
            host_bad_reg     <= 1'b0;
        end
        else if (take)
        begin
            if (last_byte)
            begin
                pos_reg          <= '0;
                phase_reg        <= PH_SCHEME;
                prev0_reg        <= '0;
                prev1_reg        <= '0;
                http_ok_reg      <= 1'b1;
                tail_ok_reg      <= 1'b0;
                scheme_len_reg   <= '0;
                domain_len_reg   <= '0;
                host_len_reg     <= '0;
                port_acc_reg     <= '0;
                digits_ended_reg <= 1'b0;
                colon_reg        <= 1'b0;
                host_bad_reg     <= 1'b0;
            end
            else
            begin
                pos_reg          <= pos_next;
                phase_reg        <= phase_next;
                prev0_reg        <= prev0_next;
                prev1_reg        <= prev1_next;
                http_ok_reg      <= http_ok_next;
                tail_ok_reg      <= tail_ok_next;
                scheme_len_reg   <= scheme_len_next;
                domain_len_reg   <= domain_len_next;
                host_len_reg     <= host_len_next;
                port_acc_reg     <= port_acc_next;
                digits_ended_reg <= digits_ended_next;
                colon_reg        <= colon_next;
                host_bad_reg     <= host_bad_next;
            end
        end
    end

    assign pos_wide    = {{LEN_W{1'b0}}, pos_next};
    assign scheme_wide = {{LEN_W{1'b0}}, scheme_len_next};

    assign summary.too_long         = pos_next > POS_LIMIT;
    assign summary.sep_seen         = phase_next != PH_SCHEME;
    assign summary.url_len          = pos_wide[LEN_W-1:0];
    assign summary.scheme_len       = scheme_wide[LEN_W-1:0];
    assign summary.scheme_len_http  = scheme_len_next == PW'(HTTP_LEN);
    assign summary.scheme_len_https = scheme_len_next == PW'(HTTPS_LEN);
    assign summary.http_prefix_ok   = http_ok_next;
    assign summary.https_tail_ok    = tail_ok_next;
    assign summary.host_len         = host_len_next;
    assign summary.domain_len       = domain_len_next;
    assign summary.port_acc         = port_acc_next;
    assign summary.colon_seen       = colon_next;
    assign summary.host_bad         = host_bad_next;

endmodule

`default_nettype wire

[rtl/core/url_authority_splitter_core.sv]
// Top level of the URL authority splitter: byte parser plus result register.
// Throughput: one URL byte per cycle, sustained, with results taken as offered.
// Latency: the result for a URL is valid the cycle after its last byte is accepted.
// A byte is refused only while a finished result sits unclaimed in the result register.
// Reset (rst_n low, asynchronous) returns the parser to the scheme phase and drops
// any pending result; the block is ready for the first byte straight after reset.
`default_nettype none

module url_authority_splitter_core
    import uas_pkg::*;
#(
    parameter int unsigned MAX_URL_LENGTH = 4096
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    uas_byte_if.sink     url,
    uas_result_if.source result
);

    uas_summary_t      summary;
    logic              take;
    logic              finish;

    logic              valid_reg;
    logic [LEN_W-1:0]  scheme_len_reg, scheme_len_next;
    logic [LEN_W-1:0]  host_len_reg, host_len_next;
    logic [LEN_W-1:0]  domain_len_reg, domain_len_next;
    logic [PORT_W-1:0] port_reg, port_next;
    logic              explicit_reg, explicit_next;
    logic [LEN_W-1:0]  uri_start_reg, uri_start_next;
    logic [LEN_W-1:0]  url_len_reg, url_len_next;
    err_t              err_reg, err_next;

    // Free to take a request unless the result register is full and stalled
    assign url.ready = !valid_reg || result.ready;
    assign take      = url.valid && url.ready;
    assign finish    = take && url.last_byte;

    uas_parser #(
        .MAX_URL_LENGTH (MAX_URL_LENGTH)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .url_byte  (url.url_byte),
        .last_byte (url.last_byte),
        .summary   (summary)
    );

    // Result fields from the state after the last byte.
    // Too long wins over everything and zeroes all but the length;
    // a missing "://" zeroes everything but the length too.
    always_comb
    begin
        scheme_len_next = '0;
        host_len_next   = '0;
        domain_len_next = '0;
        port_next       = '0;
        explicit_next   = 1'b0;
        uri_start_next  = '0;
        url_len_next    = summary.url_len;
        err_next        = ERR_OK;
        priority if (summary.too_long)
        begin
            url_len_next = LEN_W'(MAX_URL_LENGTH);
            err_next     = ERR_TOO_LONG;
        end
        else if (!summary.sep_seen)
        begin
            err_next = ERR_NO_SEP;
        end
        else
        begin
            scheme_len_next = summary.scheme_len;
            host_len_next   = summary.host_len;
            domain_len_next = summary.domain_len;
            explicit_next   = summary.colon_seen;
            uri_start_next  = summary.scheme_len + LEN_W'(3) + summary.domain_len;
            // explicit port first, then the scheme defaults
            priority if (summary.colon_seen)
                port_next = summary.port_acc;
            else if (summary.http_prefix_ok && summary.scheme_len_http)
                port_next = PORT_HTTP;
            else if (summary.http_prefix_ok && summary.https_tail_ok
                     && summary.scheme_len_https)
                port_next = PORT_HTTPS;
            else
                err_next = ERR_SCHEME;
            // a bad host character outranks an unknown scheme
            if (summary.host_bad)
                err_next = ERR_HOST_CHAR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (finish)
            valid_reg <= 1'b1;
        else if (result.ready)
            valid_reg <= 1'b0;
    end

    // Payload needs no reset; it is loaded alongside the valid flag
    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            scheme_len_reg <= scheme_len_next;
            host_len_reg   <= host_len_next;
            domain_len_reg <= domain_len_next;
            port_reg       <= port_next;
            explicit_reg   <= explicit_next;
            uri_start_reg  <= uri_start_next;
            url_len_reg    <= url_len_next;
            err_reg        <= err_next;
        end
    end

    assign result.valid         = valid_reg;
    assign result.scheme_length = scheme_len_reg;
    assign result.host_length   = host_len_reg;
    assign result.domain_length = domain_len_reg;
    assign result.port_number   = port_reg;
    assign result.port_explicit = explicit_reg;
    assign result.uri_start     = uri_start_reg;
    assign result.url_length    = url_len_reg;
    assign result.error_code    = err_reg;

endmodule

`default_nettype wire

[rtl/core/uas_checker.sv]
// Port-level checks for the URL authority splitter, bound to the top level.
`default_nettype none

module uas_checker
    import uas_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              url_valid,
    input wire logic              url_ready,
    input wire logic              url_last,
    input wire logic              result_valid,
    input wire logic              result_ready,
    input wire logic [LEN_W-1:0]  host_length,
    input wire logic [PORT_W-1:0] port_number,
    input wire logic              port_explicit,
    input wire logic [LEN_W-1:0]  uri_start,
    input wire logic [LEN_W-1:0]  url_length,
    input wire logic [2:0]        error_code
);

    // A stalled result keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(url_length)
            && $stable(error_code) && $stable(port_number))
        else $error("uas: stalled result changed");

    // With no pending result the block always takes a request
    assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> url_ready)
        else $error("uas: input stalled without a pending result");

    // The last byte of a URL yields a result on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        url_valid && url_ready && url_last |=> result_valid)
        else $error("uas: missing result after last byte");

    // A too-long or separator-less URL carries nothing but its length
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (error_code == ERR_TOO_LONG || error_code == ERR_NO_SEP)
            |-> port_number == '0 && !port_explicit
                && host_length == '0 && uri_start == '0)
        else $error("uas: fields set on a rejected URL");

endmodule

bind url_authority_splitter_core uas_checker u_uas_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .url_valid     (url.valid),
    .url_ready     (url.ready),
    .url_last      (url.last_byte),
    .result_valid  (result.valid),
    .result_ready  (result.ready),
    .host_length   (result.host_length),
    .port_number   (result.port_number),
    .port_explicit (result.port_explicit),
    .uri_start     (result.uri_start),
    .url_length    (result.url_length),
    .error_code    (result.error_code)
);

`default_nettype wire
